### src/swrm_pkg.sv
// Shared types, widths and constants of the sliding-window rate meter.
package swrm_pkg;

    localparam int TIME_W          = 32;
    localparam int BYTES_W         = 48;
    localparam int PIECES_W        = 20;
    localparam int FRAC_W          = 17;
    localparam int PIECE_BYTES_W   = 27;
    localparam int TOTAL_W         = 40;
    localparam int TOTAL_HALF_W    = 20;
    localparam int OUT_COUNT_W     = 7;
    localparam int FRAC_SHIFT      = 16;
    localparam int DIVIDEND_W      = 58;
    localparam int DIVISOR_W       = 32;
    localparam int MIN_SAMPLES     = 4;

    localparam int DEFAULT_HISTORY_DEPTH = 64;

    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 56;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;
    localparam int REG_SEL_LSB = 3;

    localparam logic [PIECE_BYTES_W-1:0] PIECE_BYTES_RST = PIECE_BYTES_W'(16384);
    localparam logic [TOTAL_W-1:0]       TOTAL_SIZE_RST  = '0;
    localparam logic [TIME_W-1:0]        WINDOW_MS_RST   = TIME_W'(10000);

    typedef enum logic [1:0] {
        REG_PIECE_BYTES = 2'd0,
        REG_TOTAL_SIZE  = 2'd1,
        REG_WINDOW_MS   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [PIECE_BYTES_W-1:0] piece_bytes;
        logic [TOTAL_W-1:0]       total_file_bytes;
        logic [TIME_W-1:0]        window_ms;
    } t_cfg;

    typedef struct packed {
        logic                mode;
        logic [TIME_W-1:0]   now_ms;
        logic [PIECES_W-1:0] pieces_held;
        logic [FRAC_W-1:0]   progress_frac;
    } t_item;

    typedef struct packed {
        logic [BYTES_W-1:0]     speed_bytes_per_s;
        logic                   speed_valid;
        logic [OUT_COUNT_W-1:0] sample_count;
    } t_result;

    typedef struct packed {
        logic [TIME_W-1:0]  stamp;
        logic [BYTES_W-1:0] bytes;
    } t_sample;

endpackage

### src/swrm_mem.sv
// Sample ring memory: one write port and one registered read port.
module swrm_mem #(
    parameter int DEPTH = swrm_pkg::DEFAULT_HISTORY_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  swrm_pkg::t_sample        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output swrm_pkg::t_sample        o_rdata
);
    import swrm_pkg::*;

    t_sample r_mem [DEPTH];
    t_sample r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/swrm_div.sv
// Restoring divider that produces one quotient bit per cycle.
module swrm_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [swrm_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  logic [swrm_pkg::DIVISOR_W-1:0]      i_divisor,
    output logic                                o_done,
    output logic [swrm_pkg::DIVIDEND_W-1:0]     o_quotient
);
    import swrm_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_div;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIVISOR_W:0]    w_shifted;
    logic                  w_ge;
    logic [DIVISOR_W:0]    w_sub;

    always_comb begin
        w_shifted = {r_rem, r_quo[DIVIDEND_W-1]};
        w_ge      = w_shifted >= {1'b0, r_div};
        w_sub     = w_shifted - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
                r_cnt  <= CNT_W'(DIVIDEND_W - 1);
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sub[DIVISOR_W-1:0] : w_shifted[DIVISOR_W-1:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### src/swrm_ctrl.sv
// Sequencer: forms the byte count, updates and prunes the ring, and computes the rate.
module swrm_ctrl #(
    parameter int DEPTH = swrm_pkg::DEFAULT_HISTORY_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  swrm_pkg::t_cfg                      i_cfg,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  swrm_pkg::t_item                     i_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output swrm_pkg::t_result                   o_result,
    output logic                                o_mem_we,
    output logic [$clog2(DEPTH)-1:0]            o_mem_waddr,
    output swrm_pkg::t_sample                   o_mem_wdata,
    output logic                                o_mem_re,
    output logic [$clog2(DEPTH)-1:0]            o_mem_raddr,
    input  swrm_pkg::t_sample                   i_mem_rdata,
    output logic                                o_div_start,
    output logic [swrm_pkg::DIVIDEND_W-1:0]     o_dividend,
    output logic [swrm_pkg::DIVISOR_W-1:0]      o_divisor,
    input  logic                                i_div_done,
    input  logic [swrm_pkg::DIVIDEND_W-1:0]     i_quotient
);
    import swrm_pkg::*;

    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int SW     = $clog2(2 * DEPTH);
    localparam int PP_W   = PIECES_W + PIECE_BYTES_W;
    localparam int PH_W   = FRAC_W + TOTAL_HALF_W;
    localparam int PROG_W = FRAC_W + TOTAL_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_APPEND,
        S_PRUNE_RD,
        S_PRUNE_CHK,
        S_NEW,
        S_SCALE,
        S_DIV,
        S_DONE
    } t_state;

    t_state              r_state;
    t_item               r_item;
    logic [AW-1:0]       r_head;
    logic [CW-1:0]       r_fill;
    logic [PP_W-1:0]     r_from_pieces;
    logic [PH_W-1:0]     r_prog_lo;
    logic [PH_W-1:0]     r_prog_hi;
    logic [BYTES_W-1:0]  r_held;
    t_sample             r_old;
    logic [TIME_W-1:0]   r_span;
    logic [BYTES_W-1:0]  r_diff;
    logic [DIVIDEND_W-1:0] r_dividend;
    logic                r_div_start;
    logic [BYTES_W-1:0]  r_res_speed;
    logic                r_res_valid;
    logic                r_out_valid;
    t_result             r_out;

    logic [PROG_W-1:0]   w_prog;
    logic [BYTES_W-1:0]  w_from_prog;
    logic                w_append;
    logic [TIME_W-1:0]   w_age;
    logic [CW-1:0]       w_newest_off;
    logic [AW-1:0]       w_newest;

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] h, input logic [CW-1:0] o);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(o);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] h);
        return (h == AW'(DEPTH - 1)) ? '0 : h + 1'b1;
    endfunction

    always_comb begin
        w_prog       = {r_prog_hi, {TOTAL_HALF_W{1'b0}}} + PROG_W'(r_prog_lo);
        w_from_prog  = BYTES_W'(w_prog >> FRAC_SHIFT);
        w_append     = (r_fill == '0) || (r_held > i_mem_rdata.bytes);
        w_age        = r_item.now_ms - i_mem_rdata.stamp;
        w_newest_off = (r_fill == '0) ? '0 : r_fill - 1'b1;
        w_newest     = f_slot(r_head, w_newest_off);
    end

    always_comb begin
        o_mem_we          = (r_state == S_APPEND) && w_append;
        o_mem_waddr       = f_slot(r_head, r_fill);
        o_mem_wdata.stamp = r_item.now_ms;
        o_mem_wdata.bytes = r_held;
        o_mem_re          = r_state inside {S_MUL, S_PRUNE_RD, S_PRUNE_CHK};
        o_mem_raddr       = (r_state == S_PRUNE_RD) ? r_head : w_newest;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_item;
                        r_state <= i_item.mode ? S_MUL : S_PRUNE_RD;
                    end
                end
                S_MUL: begin
                    r_from_pieces <= PP_W'(r_item.pieces_held) * PP_W'(i_cfg.piece_bytes);
                    r_prog_lo     <= PH_W'(r_item.progress_frac)
                                     * PH_W'(i_cfg.total_file_bytes[TOTAL_HALF_W-1:0]);
                    r_prog_hi     <= PH_W'(r_item.progress_frac)
                                     * PH_W'(i_cfg.total_file_bytes[TOTAL_W-1:TOTAL_HALF_W]);
                    r_state       <= S_SUM;
                end
                S_SUM: begin
                    r_held  <= (BYTES_W'(r_from_pieces) > w_from_prog)
                               ? BYTES_W'(r_from_pieces) : w_from_prog;
                    r_state <= S_APPEND;
                end
                S_APPEND: begin
                    if (w_append) begin
                        if (r_fill == CW'(DEPTH)) begin
                            r_head <= f_inc(r_head);
                        end else begin
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                    r_state <= S_PRUNE_RD;
                end
                S_PRUNE_RD: begin
                    if (r_fill == '0) begin
                        r_res_speed <= '0;
                        r_res_valid <= 1'b0;
                        r_state     <= S_DONE;
                    end else begin
                        r_state <= S_PRUNE_CHK;
                    end
                end
                S_PRUNE_CHK: begin
                    if (w_age > i_cfg.window_ms) begin
                        r_head  <= f_inc(r_head);
                        r_fill  <= r_fill - 1'b1;
                        r_state <= S_PRUNE_RD;
                    end else if (r_fill < CW'(MIN_SAMPLES)) begin
                        r_res_speed <= '0;
                        r_res_valid <= 1'b0;
                        r_state     <= S_DONE;
                    end else begin
                        r_old   <= i_mem_rdata;
                        r_state <= S_NEW;
                    end
                end
                S_NEW: begin
                    r_span  <= i_mem_rdata.stamp - r_old.stamp;
                    r_diff  <= i_mem_rdata.bytes - r_old.bytes;
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    if (r_span == '0) begin
                        r_res_speed <= '0;
                        r_res_valid <= 1'b0;
                        r_state     <= S_DONE;
                    end else begin
                        r_dividend  <= (DIVIDEND_W'(r_diff) << 10) - (DIVIDEND_W'(r_diff) << 4)
                                       - (DIVIDEND_W'(r_diff) << 3);
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (i_div_done) begin
                        r_res_speed <= (|i_quotient[DIVIDEND_W-1:BYTES_W])
                                       ? '1 : i_quotient[BYTES_W-1:0];
                        r_res_valid <= 1'b1;
                        r_state     <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid             <= 1'b1;
                        r_out.speed_bytes_per_s <= r_res_speed;
                        r_out.speed_valid       <= r_res_valid;
                        r_out.sample_count      <= OUT_COUNT_W'(r_fill);
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;
    assign o_div_start = r_div_start;
    assign o_dividend  = r_dividend;
    assign o_divisor   = r_span;

endmodule

### src/sliding_window_rate_meter_core.sv
// Top level of the sliding-window rate meter: register port, stream ports and block wiring.
//
// Each beat carries a timestamp and, in report mode, a piece count and progress; the block keeps
// a ring of up to HISTORY_DEPTH (time, bytes) samples in a single-port-write memory and answers
// every beat with one rate beat. Report mode adds the byte-count multiply and ring update, the
// age check reads samples from the oldest on through the memory read port, and a rate result
// goes through the span set-up and the 58-step bit-serial divider. The next beat is accepted as
// soon as the previous result has moved to the output register, and no clearing pass is needed
// after reset.
module sliding_window_rate_meter_core #(
    parameter int HISTORY_DEPTH = swrm_pkg::DEFAULT_HISTORY_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [swrm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [swrm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [swrm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // now_ms [31:0], pieces held [51:32], progress_frac [68:52], zero fill [71:69]
    input  logic [swrm_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // mode
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // speed_bytes_per_s [47:0], sample_count [54:48], zero fill [55]
    output logic [swrm_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    // speed_valid
    output logic                              o_m_axis_tuser
);
    import swrm_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);

    t_cfg              r_cfg;
    t_item             w_item;
    t_result           w_result;
    t_reg_idx          w_reg;

    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    t_sample           w_mem_wdata;
    logic              w_mem_re;
    logic [AW-1:0]     w_mem_raddr;
    t_sample           w_mem_rdata;

    logic                  w_div_start;
    logic [DIVIDEND_W-1:0] w_dividend;
    logic [DIVISOR_W-1:0]  w_divisor;
    logic                  w_div_done;
    logic [DIVIDEND_W-1:0] w_quotient;

    assign pready = 1'b1;
    assign w_reg  = t_reg_idx'(paddr[REG_SEL_LSB+1:REG_SEL_LSB]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.piece_bytes      <= PIECE_BYTES_RST;
            r_cfg.total_file_bytes <= TOTAL_SIZE_RST;
            r_cfg.window_ms        <= WINDOW_MS_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (w_reg)
                REG_PIECE_BYTES: r_cfg.piece_bytes      <= pwdata[PIECE_BYTES_W-1:0];
                REG_TOTAL_SIZE:  r_cfg.total_file_bytes <= pwdata[TOTAL_W-1:0];
                REG_WINDOW_MS:   r_cfg.window_ms        <= pwdata[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_PIECE_BYTES: prdata = APB_DATA_W'(r_cfg.piece_bytes);
            REG_TOTAL_SIZE:  prdata = APB_DATA_W'(r_cfg.total_file_bytes);
            REG_WINDOW_MS:   prdata = APB_DATA_W'(r_cfg.window_ms);
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        w_item.mode          = i_s_axis_tuser;
        w_item.now_ms        = i_s_axis_tdata[TIME_W-1:0];
        w_item.pieces_held   = i_s_axis_tdata[TIME_W+PIECES_W-1:TIME_W];
        w_item.progress_frac = i_s_axis_tdata[TIME_W+PIECES_W+FRAC_W-1:TIME_W+PIECES_W];
    end

    assign o_m_axis_tdata = M_TDATA_W'({w_result.sample_count, w_result.speed_bytes_per_s});
    assign o_m_axis_tuser = w_result.speed_valid;

    swrm_ctrl #(
        .DEPTH(HISTORY_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_item      (w_item),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_result    (w_result),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_re    (w_mem_re),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata),
        .o_div_start (w_div_start),
        .o_dividend  (w_dividend),
        .o_divisor   (w_divisor),
        .i_div_done  (w_div_done),
        .i_quotient  (w_quotient)
    );

    swrm_mem #(
        .DEPTH(HISTORY_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    swrm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

endmodule

### tb/sliding_window_rate_meter_core_tb.sv
// Self-checking testbench for the sliding-window rate meter: stimulus, register writes, scoreboard.
module sliding_window_rate_meter_core_tb;
    import swrm_pkg::*;

    localparam int RING_DEPTH       = DEFAULT_HISTORY_DEPTH;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int SETTLE_CYCLES    = 2 * RING_DEPTH + 80;
    localparam int LONG_HOLD_AFTER  = 360;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int PHASES           = 12;
    localparam int PHASE_ITEMS      = 135;
    localparam int MAX_PRINTED      = 100;

    localparam logic [63:0]              MS_PER_S        = 64'd1000;
    localparam logic [BYTES_W-1:0]       SPEED_MAX       = '1;
    localparam logic                     MODE_QUERY      = 1'b0;
    localparam logic                     MODE_REPORT     = 1'b1;
    localparam logic [PIECE_BYTES_W-1:0] PIECE_BYTES_MAX = PIECE_BYTES_W'(67108864);
    localparam logic [TOTAL_W-1:0]       TOTAL_SIZE_MAX  = '1;
    localparam logic [TIME_W-1:0]        WINDOW_MAX      = '1;

    class rate_meter_scoreboard;
        logic [PIECE_BYTES_W-1:0] piece_bytes;
        logic [TOTAL_W-1:0]       file_size;
        logic [TIME_W-1:0]        window_ms;
        t_sample                  ring[RING_DEPTH];
        int unsigned              oldest;
        int unsigned              held_count;
        t_result                  expected_rates[$];
        int                       errors;
        int                       checked;

        function new();
            piece_bytes = PIECE_BYTES_RST;
            file_size   = TOTAL_SIZE_RST;
            window_ms   = WINDOW_MS_RST;
            oldest      = 0;
            held_count  = 0;
            errors      = 0;
            checked     = 0;
        endfunction

        function void apply_register(t_reg_idx idx, logic [APB_DATA_W-1:0] value);
            case (idx)
                REG_PIECE_BYTES: piece_bytes = value[PIECE_BYTES_W-1:0];
                REG_TOTAL_SIZE:  file_size   = value[TOTAL_W-1:0];
                REG_WINDOW_MS:   window_ms   = value[TIME_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned slot(int unsigned offset);
            return (oldest + offset) % RING_DEPTH;
        endfunction

        // Works out the rate beat that one accepted input beat must produce.
        function void note_item(t_item it);
            logic [63:0]         by_pieces;
            logic [63:0]         by_progress;
            logic [63:0]         held;
            logic [63:0]         quotient;
            logic [TIME_W-1:0]   age;
            logic [TIME_W-1:0]   span;
            logic [BYTES_W-1:0]  gain;
            bit                  ageing;
            int unsigned         newest;
            t_result             want;

            if (it.mode == MODE_REPORT) begin
                by_pieces   = 64'(it.pieces_held) * 64'(piece_bytes);
                by_progress = (64'(it.progress_frac) * 64'(file_size)) >> FRAC_SHIFT;
                held        = by_pieces > by_progress ? by_pieces : by_progress;
                held        = 64'(held[BYTES_W-1:0]);
                if (held_count == 0 || held > 64'(ring[slot(held_count - 1)].bytes)) begin
                    if (held_count >= RING_DEPTH) begin
                        oldest = slot(1);
                        held_count--;
                    end
                    ring[slot(held_count)].stamp = it.now_ms;
                    ring[slot(held_count)].bytes = held[BYTES_W-1:0];
                    held_count++;
                end
            end
            ageing = 1'b1;
            while (ageing && held_count != 0) begin
                age = it.now_ms - ring[oldest].stamp;
                if (age > window_ms) begin
                    oldest = slot(1);
                    held_count--;
                end else begin
                    ageing = 1'b0;
                end
            end
            want = '0;
            want.sample_count = OUT_COUNT_W'(held_count);
            if (held_count >= MIN_SAMPLES) begin
                newest = slot(held_count - 1);
                span   = ring[newest].stamp - ring[oldest].stamp;
                if (span != 0) begin
                    gain     = ring[newest].bytes - ring[oldest].bytes;
                    quotient = (64'(gain) * MS_PER_S) / 64'(span);
                    want.speed_bytes_per_s = quotient > 64'(SPEED_MAX) ?
                                             SPEED_MAX : quotient[BYTES_W-1:0];
                    want.speed_valid = 1'b1;
                end
            end
            expected_rates.insert(expected_rates.size(), want);
        endfunction

        task report_mismatch(string what);
            if (errors < MAX_PRINTED) begin
                $display("mismatch at %0t: %s", $realtime, what);
            end
            errors++;
        endtask

        task check_rate_beat(t_result got);
            t_result want;
            checked++;
            if (expected_rates.size() == 0) begin
                report_mismatch($sformatf("rate beat with nothing expected (speed %0d, count %0d)",
                                          got.speed_bytes_per_s, got.sample_count));
                return;
            end
            want = expected_rates[0];
            expected_rates.delete(0);
            if (got.speed_bytes_per_s !== want.speed_bytes_per_s) begin
                report_mismatch($sformatf("beat %0d speed %0d, expected %0d", checked,
                                          got.speed_bytes_per_s, want.speed_bytes_per_s));
            end
            if (got.speed_valid !== want.speed_valid) begin
                report_mismatch($sformatf("beat %0d speed_valid %b, expected %b", checked,
                                          got.speed_valid, want.speed_valid));
            end
            if (got.sample_count !== want.sample_count) begin
                report_mismatch($sformatf("beat %0d sample_count %0d, expected %0d", checked,
                                          got.sample_count, want.sample_count));
            end
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [S_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic                   i_s_axis_tuser = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   o_m_axis_tdata;
    logic                   o_m_axis_tuser;

    rate_meter_scoreboard   sb = new();
    int unsigned            burst_left = 0;
    int unsigned            quiet_cycles = 0;
    t_result                seen_rate;

    sliding_window_rate_meter_core dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic t_item item_of(logic mode, logic [TIME_W-1:0] now,
                                      logic [PIECES_W-1:0] pieces, logic [FRAC_W-1:0] frac);
        t_item it;
        it.mode          = mode;
        it.now_ms        = now;
        it.pieces_held   = pieces;
        it.progress_frac = frac;
        return it;
    endfunction

    task automatic offer_item(input t_item it);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                      : $urandom_range(1, 30);
            gap = $urandom_range(1, 12);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= S_TDATA_W'({it.progress_frac, it.pieces_held, it.now_ms});
        i_s_axis_tuser  <= it.mode;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_item(it);
    endtask

    task automatic drain_block();
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.expected_rates.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << REG_SEL_LSB;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.apply_register(idx, value);
    endtask

    task automatic set_registers(input logic [PIECE_BYTES_W-1:0] pb,
                                 input logic [TOTAL_W-1:0] tot,
                                 input logic [TIME_W-1:0] win);
        drain_block();
        apb_write(REG_PIECE_BYTES, APB_DATA_W'(pb));
        apb_write(REG_TOTAL_SIZE, APB_DATA_W'(tot));
        apb_write(REG_WINDOW_MS, APB_DATA_W'(win));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly growing reports at a steady pace, with queries, window-sized jumps and noise.
    task automatic run_phase(input int n_items);
        t_item                it;
        logic [TIME_W-1:0]    now;
        logic [PIECES_W-1:0]  pieces;
        logic [FRAC_W-1:0]    frac;
        logic [63:0]          jump;
        int unsigned          pick;
        now    = $urandom();
        pieces = PIECES_W'($urandom_range(0, 1000));
        frac   = FRAC_W'($urandom_range(0, 4000));
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                now += TIME_W'($urandom_range(0, 300));
                if (pick < 68) begin
                    if ($urandom_range(0, 1) == 1) begin
                        pieces += PIECES_W'($urandom_range(0, 12));
                    end else begin
                        frac += FRAC_W'($urandom_range(0, 300));
                    end
                    it = item_of(MODE_REPORT, now, pieces, frac);
                end else begin
                    it = item_of(MODE_QUERY, now, PIECES_W'($urandom()), FRAC_W'($urandom()));
                end
            end else if (pick < 93) begin
                jump = 64'(sb.window_ms) * 64'($urandom_range(1, 3)) / 2 + 1;
                now += TIME_W'(jump);
                it = item_of(1'($urandom()), now, pieces, frac);
            end else begin
                it = item_of(1'($urandom()), $urandom(), PIECES_W'($urandom()), FRAC_W'($urandom()));
                if ($urandom_range(0, 1) == 1) begin
                    now    = it.now_ms;
                    pieces = it.pieces_held;
                    frac   = it.progress_frac;
                end
            end
            offer_item(it);
        end
    endtask

    initial begin
        logic [TIME_W-1:0]        t0;
        logic [TIME_W-1:0]        t1;
        logic [PIECE_BYTES_W-1:0] pb;
        logic [TOTAL_W-1:0]       tot;
        logic [TIME_W-1:0]        win;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset settings, timestamps that wrap through zero.
        t0 = 32'hFFFF_FF00;
        offer_item(item_of(MODE_QUERY, t0, '0, '0));
        offer_item(item_of(MODE_REPORT, t0, '0, '0));
        offer_item(item_of(MODE_REPORT, t0 + 10, '0, '0));
        offer_item(item_of(MODE_REPORT, t0 + 100, 20'd1, '0));
        offer_item(item_of(MODE_REPORT, t0 + 200, 20'd2, '0));
        offer_item(item_of(MODE_REPORT, t0 + 300, 20'd3, '0));
        offer_item(item_of(MODE_QUERY, t0 + 10300, '0, '0));
        offer_item(item_of(MODE_QUERY, t0 + 20301, '0, '0));
        t0 += 40000;
        offer_item(item_of(MODE_REPORT, t0, 20'd5, '0));
        offer_item(item_of(MODE_REPORT, t0, 20'd6, '0));
        offer_item(item_of(MODE_REPORT, t0, 20'd7, '0));
        offer_item(item_of(MODE_REPORT, t0, 20'd8, '0));
        offer_item(item_of(MODE_REPORT, t0 + 1, 20'd9, '0));

        // Largest sizes: progress at and above complete, saturating rate.
        t1 = 32'h8000_0000;
        offer_item(item_of(MODE_QUERY, t1, '0, '0));
        set_registers(PIECE_BYTES_MAX, TOTAL_SIZE_MAX, WINDOW_MAX);
        offer_item(item_of(MODE_REPORT, t1, 20'd1, '0));
        offer_item(item_of(MODE_REPORT, t1 + 1, '0, 17'h10000));
        offer_item(item_of(MODE_REPORT, t1 + 2, '0, 17'h1FFFF));
        offer_item(item_of(MODE_REPORT, t1 + 3, 20'hFFFFF, '0));
        offer_item(item_of(MODE_REPORT, t1 + 4, 20'hFFFFF, 17'h1FFFF));
        offer_item(item_of(MODE_QUERY, t1 + 5, 20'hFFFFF, 17'h1FFFF));
        set_registers(PIECE_BYTES_MAX, TOTAL_SIZE_MAX, '0);
        offer_item(item_of(MODE_QUERY, t1 + 6, '0, '0));
        offer_item(item_of(MODE_REPORT, t1 + 7, 20'd2, '0));
        offer_item(item_of(MODE_QUERY, t1 + 7, '0, '0));

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_registers(PIECE_BYTES_RST, TOTAL_SIZE_RST, WINDOW_MS_RST);
                1: set_registers(PIECE_BYTES_MAX, TOTAL_SIZE_MAX, WINDOW_MAX);
                2: set_registers('0, '0, '0);
                default: begin
                    pb  = ($urandom_range(0, 1) == 1) ? PIECE_BYTES_W'($urandom_range(1, 67108864))
                                                      : PIECE_BYTES_W'($urandom_range(1, 4096));
                    tot = ($urandom_range(0, 2) == 0) ? TOTAL_W'($urandom_range(1, 100000))
                                                      : TOTAL_W'({$urandom(), $urandom()});
                    win = ($urandom_range(0, 1) == 1) ? TIME_W'($urandom_range(1, 20000))
                                                      : TIME_W'($urandom_range(20000, 200000));
                    set_registers(pb, tot, win);
                end
            endcase
            run_phase(PHASE_ITEMS);
        end

        drain_block();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.expected_rates.size() != 0) begin
            sb.report_mismatch($sformatf("%0d rate beats never arrived",
                                         sb.expected_rates.size()));
        end
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Receiver: segments of steady, random and periodic back-pressure, plus one long hold-off.
    initial begin
        int unsigned seg_kind;
        int unsigned seg_left;
        int unsigned hold_left;
        bit          held_once;
        seg_kind  = 0;
        seg_left  = 0;
        hold_left = 0;
        held_once = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held_once && sb.checked >= LONG_HOLD_AFTER) begin
                held_once = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (seg_left == 0) begin
                seg_kind = $urandom_range(0, 2);
                seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            if (hold_left != 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                case (seg_kind)
                    0: i_m_axis_tready <= 1'b1;
                    1: i_m_axis_tready <= ($urandom_range(0, 99) >= 35);
                    default: i_m_axis_tready <= (seg_left % 4 != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen_rate.speed_bytes_per_s = o_m_axis_tdata[BYTES_W-1:0];
            seen_rate.sample_count      = o_m_axis_tdata[BYTES_W +: OUT_COUNT_W];
            seen_rate.speed_valid       = o_m_axis_tuser;
            sb.check_rate_beat(seen_rate);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
